FILE: sv/sawarq_pkg.sv
// Shared types and codes for the stop-and-wait ARQ sender.
`timescale 1ns / 1ps

package sawarq_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HELLO = 3'd1,
        PH_OPEN  = 3'd2,
        PH_DATA  = 3'd3,
        PH_CLOSE = 3'd4
    } phase_t;

    // event codes (input tuser)
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_LINE  = 3'd1;
    localparam logic [2:0] CMD_EOF   = 3'd2;
    localparam logic [2:0] CMD_REPLY = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    localparam logic [1:0] REPLY_ACK   = 2'd0;
    localparam logic [1:0] REPLY_NACK  = 2'd1;
    localparam logic [1:0] REPLY_OTHER = 2'd2;

    localparam logic [1:0] PKT_HELLO = 2'd0;
    localparam logic [1:0] PKT_DATA  = 2'd1;
    localparam logic [1:0] PKT_CLOSE = 2'd2;

    localparam logic ACT_TX     = 1'b0;
    localparam logic ACT_STATUS = 1'b1;

    localparam logic [3:0] ST_NONE           = 4'd0;
    localparam logic [3:0] ST_OPEN           = 4'd1;
    localparam logic [3:0] ST_LINE_ACKED     = 4'd2;
    localparam logic [3:0] ST_LINE_DROPPED   = 4'd3;
    localparam logic [3:0] ST_DONE           = 4'd4;
    localparam logic [3:0] ST_HELLO_REJECTED = 4'd5;
    localparam logic [3:0] ST_HELLO_TIMEOUT  = 4'd6;
    localparam logic [3:0] ST_CLOSE_REJECTED = 4'd7;
    localparam logic [3:0] ST_CLOSE_TIMEOUT  = 4'd8;

    localparam logic REG_RETRY_LIMIT   = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd3;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd300;
    localparam logic [31:0] FIRST_SEQUENCE    = 32'd1;
    localparam logic [15:0] TIMER_MAX         = 16'hFFFF;

    typedef struct packed {
        logic        action;
        logic [1:0]  packet_kind;
        logic [31:0] sequence_res;
        logic [7:0]  payload_ref;
        logic [3:0]  status;
    } result_t;

endpackage

FILE: sv/stop_and_wait_arq_sender.sv
// Stop-and-wait ARQ sender: session sequencer with registered input and result stages.
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tuser cmd, tdata data_ref, reply_kind
//  m_axis  | out | m_axis_tvalid/tready   | tuser action, tdata packet/status fields
//  cfg     | in  | cfg_we                 | cfg_index, cfg_data
//
// One event per clock cycle while m_axis does not stall; an event passes the input register, then the result register.
// Every event is handled in one pass through the session state update between
// the input register and the result register.
// rst_n clears the session state, the registers to their defaults and both valids.
// A stall on m_axis holds the input stage; s_axis_tready falls only while both
// stages are full and the result is not taken.
`timescale 1ns / 1ps

module stop_and_wait_arq_sender
    import sawarq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_ref, [9:8] reply_kind, zero fill
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [1:0] packet_kind, [33:2] sequence_res,
                                        // [41:34] payload_ref, [45:42] status, zero fill
    output logic        m_axis_tuser,   // [0] action
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [3:0]  retry_limit_reg;
    logic [15:0] timeout_ticks_reg;

    logic        in_valid_reg;
    logic [2:0]  cmd_reg;
    logic [7:0]  data_ref_reg;
    logic [1:0]  reply_kind_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] next_sequence_reg, next_sequence_next;
    logic [3:0]  retry_count_reg, retry_count_next;
    logic [15:0] wait_timer_reg, wait_timer_next;
    logic [7:0]  held_ref_reg, held_ref_next;

    logic        out_valid_reg;
    result_t     result_reg, result_next;
    logic        has_result;

    logic        out_free, fire, waiting, is_ack;
    logic [15:0] timer_inc, limit_t;
    logic [3:0]  retry_inc, limit_r;
    logic        timed_out, drop;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;

    assign waiting = (phase_reg == PH_HELLO) || (phase_reg == PH_DATA)
                     || (phase_reg == PH_CLOSE);
    assign is_ack  = (reply_kind_reg == REPLY_ACK);

    assign timer_inc = (wait_timer_reg != TIMER_MAX) ? wait_timer_reg + 16'd1
                                                     : wait_timer_reg;
    assign limit_t   = (timeout_ticks_reg == '0) ? 16'd1 : timeout_ticks_reg;
    assign timed_out = (timer_inc >= limit_t);
    assign retry_inc = retry_count_reg + 4'd1;
    assign limit_r   = (retry_limit_reg == '0) ? 4'd1 : retry_limit_reg;
    // a wrap of the retry count also drops the line
    assign drop      = (retry_inc >= limit_r) || (retry_inc == '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (cmd_reg)
            CMD_START:
                if (phase_reg == PH_IDLE)
                    phase_next = PH_HELLO;
            CMD_LINE:
                if (phase_reg == PH_OPEN)
                    phase_next = PH_DATA;
            CMD_EOF:
                if (phase_reg == PH_OPEN)
                    phase_next = PH_CLOSE;
            CMD_REPLY:
                case (phase_reg)
                    PH_HELLO: phase_next = is_ack ? PH_OPEN : PH_IDLE;
                    PH_CLOSE: phase_next = PH_IDLE;
                    PH_DATA:  phase_next = is_ack ? PH_OPEN : PH_DATA;
                    default:  phase_next = phase_reg;
                endcase
            CMD_TICK:
                if (waiting && timed_out)
                begin
                    case (phase_reg)
                        PH_HELLO: phase_next = PH_IDLE;
                        PH_CLOSE: phase_next = PH_IDLE;
                        PH_DATA:  phase_next = drop ? PH_OPEN : PH_DATA;
                        default:  phase_next = phase_reg;
                    endcase
                end
            default:
                phase_next = phase_reg;
        endcase
    end

    // result and session counters
    always_comb
    begin
        has_result         = 1'b0;
        result_next        = '0;
        next_sequence_next = next_sequence_reg;
        retry_count_next   = retry_count_reg;
        wait_timer_next    = wait_timer_reg;
        held_ref_next      = held_ref_reg;
        case (cmd_reg)
            CMD_START:
                if (phase_reg == PH_IDLE)
                begin
                    has_result              = 1'b1;
                    result_next.action      = ACT_TX;
                    result_next.packet_kind = PKT_HELLO;
                    next_sequence_next      = FIRST_SEQUENCE;
                    retry_count_next        = '0;
                    held_ref_next           = '0;
                    wait_timer_next         = '0;
                end
            CMD_LINE:
                if (phase_reg == PH_OPEN)
                begin
                    has_result               = 1'b1;
                    result_next.action       = ACT_TX;
                    result_next.packet_kind  = PKT_DATA;
                    result_next.sequence_res = next_sequence_reg;
                    result_next.payload_ref  = data_ref_reg;
                    held_ref_next            = data_ref_reg;
                    retry_count_next         = '0;
                    wait_timer_next          = '0;
                end
            CMD_EOF:
                if (phase_reg == PH_OPEN)
                begin
                    has_result              = 1'b1;
                    result_next.action      = ACT_TX;
                    result_next.packet_kind = PKT_CLOSE;
                    wait_timer_next         = '0;
                end
            CMD_REPLY:
                if (waiting)
                begin
                    has_result      = 1'b1;
                    wait_timer_next = '0;
                    case (phase_reg)
                        PH_HELLO:
                        begin
                            result_next.action = ACT_STATUS;
                            result_next.status = is_ack ? ST_OPEN : ST_HELLO_REJECTED;
                        end
                        PH_CLOSE:
                        begin
                            result_next.action = ACT_STATUS;
                            result_next.status = is_ack ? ST_DONE : ST_CLOSE_REJECTED;
                        end
                        default:
                            if (is_ack)
                            begin
                                result_next.action = ACT_STATUS;
                                result_next.status = ST_LINE_ACKED;
                                next_sequence_next = next_sequence_reg + 32'd1;
                                retry_count_next   = '0;
                            end
                            else
                            begin
                                // nack or other: resend, retry count unchanged
                                result_next.action       = ACT_TX;
                                result_next.packet_kind  = PKT_DATA;
                                result_next.sequence_res = next_sequence_reg;
                                result_next.payload_ref  = held_ref_reg;
                            end
                    endcase
                end
            CMD_TICK:
                if (waiting)
                begin
                    wait_timer_next = timer_inc;
                    if (timed_out)
                    begin
                        has_result      = 1'b1;
                        wait_timer_next = '0;
                        case (phase_reg)
                            PH_HELLO:
                            begin
                                result_next.action = ACT_STATUS;
                                result_next.status = ST_HELLO_TIMEOUT;
                            end
                            PH_CLOSE:
                            begin
                                result_next.action = ACT_STATUS;
                                result_next.status = ST_CLOSE_TIMEOUT;
                            end
                            default:
                                if (drop)
                                begin
                                    result_next.action = ACT_STATUS;
                                    result_next.status = ST_LINE_DROPPED;
                                    next_sequence_next = next_sequence_reg + 32'd1;
                                    retry_count_next   = '0;
                                end
                                else
                                begin
                                    result_next.action       = ACT_TX;
                                    result_next.packet_kind  = PKT_DATA;
                                    result_next.sequence_res = next_sequence_reg;
                                    result_next.payload_ref  = held_ref_reg;
                                    retry_count_next         = retry_inc;
                                end
                        endcase
                    end
                end
            default:
                has_result = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= RETRY_LIMIT_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_RETRY_LIMIT)
                retry_limit_reg <= cfg_data[3:0];
            else
                timeout_ticks_reg <= cfg_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_IDLE;
            next_sequence_reg <= FIRST_SEQUENCE;
            retry_count_reg   <= '0;
            wait_timer_reg    <= '0;
            held_ref_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (fire)
            begin
                out_valid_reg     <= has_result;
                phase_reg         <= phase_next;
                next_sequence_reg <= next_sequence_next;
                retry_count_reg   <= retry_count_next;
                wait_timer_reg    <= wait_timer_next;
                held_ref_reg      <= held_ref_next;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cmd_reg        <= s_axis_tuser;
            data_ref_reg   <= s_axis_tdata[7:0];
            reply_kind_reg <= s_axis_tdata[9:8];
        end
        if (fire)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.action;
    assign m_axis_tdata  = {2'b00, result_reg.status, result_reg.payload_ref,
                            result_reg.sequence_res, result_reg.packet_kind};

    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> wait_timer_reg == '0)
        else $error("timer left running in idle phase");

    a_open_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OPEN |-> (retry_count_reg == '0 && wait_timer_reg == '0))
        else $error("open phase with stale retry count or timer");

    a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        fire && has_result |=> m_axis_tvalid)
        else $error("result lost between stages");

    a_tx_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_TX |-> m_axis_tdata[45:42] == ST_NONE)
        else $error("transmit result carries a status");

endmodule

FILE: test/tb_stop_and_wait_arq_sender.sv
// Self-checking testbench for the stop-and-wait ARQ sender: directed sessions, then random traffic.
`timescale 1ns / 1ps

module tb_stop_and_wait_arq_sender;
    import sawarq_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [7:0] data_ref, [9:8] reply_kind, zero fill
    logic [2:0]  s_axis_tuser = '0;    // [2:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [1:0] packet_kind, [33:2] sequence_res,
                                       // [41:34] payload_ref, [45:42] status, zero fill
    logic        m_axis_tuser;         // [0] action
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    // session predictor state
    phase_t      sess_phase  = PH_IDLE;
    logic [31:0] next_seq    = FIRST_SEQUENCE;
    logic [3:0]  retry_cnt   = '0;
    logic [15:0] wait_timer  = '0;
    logic [7:0]  held_slot   = '0;
    logic [3:0]  cfg_retry   = RETRY_LIMIT_RST;
    logic [15:0] cfg_timeout = TIMEOUT_TICKS_RST;

    result_t     pending_results[$];

    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int unsigned rx_stall_left = 0;
    bit          last_acted;
    int unsigned error_count = 0;
    int unsigned events_sent = 0;
    int unsigned events_acted = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes = 0;
    int unsigned quiet_cycles = 0;

    stop_and_wait_arq_sender u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic result_t tx_packet(input logic [1:0] kind, input logic [31:0] seq,
                                          input logic [7:0] slot);
        result_t r;
        r = '0;
        r.action       = ACT_TX;
        r.packet_kind  = kind;
        r.sequence_res = seq;
        r.payload_ref  = slot;
        r.status       = ST_NONE;
        wait_timer     = '0;
        return r;
    endfunction

    function automatic result_t status_report(input logic [3:0] st);
        result_t r;
        r = '0;
        r.action = ACT_STATUS;
        r.status = st;
        return r;
    endfunction

    function automatic result_t finish_line(input logic [3:0] st);
        next_seq   = next_seq + 32'd1;
        retry_cnt  = '0;
        wait_timer = '0;
        sess_phase = PH_OPEN;
        return status_report(st);
    endfunction

    function automatic result_t end_session(input logic [3:0] st);
        sess_phase = PH_IDLE;
        wait_timer = '0;
        return status_report(st);
    endfunction

    // Applies one event to the session state; returns 1 when a result is due.
    // acted is 0 for events the block drops because they do not fit the phase.
    function automatic bit advance_session(input logic [2:0] cmd, input logic [7:0] slot,
                                           input logic [1:0] kind, output result_t res,
                                           output bit acted);
        bit          waiting;
        bit          produced;
        logic [15:0] tick_limit;
        logic [3:0]  retry_max;
        waiting  = (sess_phase == PH_HELLO) || (sess_phase == PH_DATA)
                   || (sess_phase == PH_CLOSE);
        res      = '0;
        acted    = 1'b0;
        produced = 1'b0;
        case (cmd)
            CMD_START:
                if (sess_phase == PH_IDLE)
                begin
                    next_seq   = FIRST_SEQUENCE;
                    retry_cnt  = '0;
                    held_slot  = '0;
                    sess_phase = PH_HELLO;
                    res        = tx_packet(PKT_HELLO, '0, '0);
                    produced   = 1'b1;
                end
            CMD_LINE:
                if (sess_phase == PH_OPEN)
                begin
                    held_slot  = slot;
                    retry_cnt  = '0;
                    sess_phase = PH_DATA;
                    res        = tx_packet(PKT_DATA, next_seq, held_slot);
                    produced   = 1'b1;
                end
            CMD_EOF:
                if (sess_phase == PH_OPEN)
                begin
                    sess_phase = PH_CLOSE;
                    res        = tx_packet(PKT_CLOSE, '0, '0);
                    produced   = 1'b1;
                end
            CMD_REPLY:
                if (waiting)
                begin
                    produced = 1'b1;
                    if (sess_phase == PH_HELLO)
                    begin
                        if (kind == REPLY_ACK)
                        begin
                            sess_phase = PH_OPEN;
                            wait_timer = '0;
                            res        = status_report(ST_OPEN);
                        end
                        else
                            res = end_session(ST_HELLO_REJECTED);
                    end
                    else if (sess_phase == PH_CLOSE)
                        res = end_session(kind == REPLY_ACK ? ST_DONE : ST_CLOSE_REJECTED);
                    else if (kind == REPLY_ACK)
                        res = finish_line(ST_LINE_ACKED);
                    else
                        res = tx_packet(PKT_DATA, next_seq, held_slot);   // any reply but ack: resend now
                end
            CMD_TICK:
                if (waiting)
                begin
                    acted      = 1'b1;
                    tick_limit = (cfg_timeout == '0) ? 16'd1 : cfg_timeout;
                    if (wait_timer != TIMER_MAX)
                        wait_timer = wait_timer + 16'd1;
                    if (wait_timer >= tick_limit)
                    begin
                        wait_timer = '0;
                        produced   = 1'b1;
                        if (sess_phase == PH_HELLO)
                            res = end_session(ST_HELLO_TIMEOUT);
                        else if (sess_phase == PH_CLOSE)
                            res = end_session(ST_CLOSE_TIMEOUT);
                        else
                        begin
                            retry_max = (cfg_retry == '0) ? 4'd1 : cfg_retry;
                            retry_cnt = retry_cnt + 4'd1;
                            if (retry_cnt >= retry_max || retry_cnt == '0)
                                res = finish_line(ST_LINE_DROPPED);
                            else
                                res = tx_packet(PKT_DATA, next_seq, held_slot);
                        end
                    end
                end
            default: ;
        endcase
        if (produced)
            acted = 1'b1;
        return produced;
    endfunction

    task automatic send_event(input logic [2:0] cmd, input logic [7:0] slot,
                              input logic [1:0] kind);
        result_t res;
        bit      produced;
        bit      acted;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, kind, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        produced = advance_session(cmd, slot, kind, res, acted);
        if (produced)
            pending_results.push_back(res);
        events_sent++;
        if (acted)
            events_acted++;
        last_acted = acted;
    endtask

    // Drop valid and let everything in flight drain out, dropped events included.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_RETRY_LIMIT)
            cfg_retry = value[3:0];
        else
            cfg_timeout = value;
        cfg_writes++;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_event(CMD_TICK, 8'($urandom_range(0, 255)),
                                  2'($urandom_range(0, 3)));
    endtask

    task automatic send_reply(input logic [1:0] kind);
        send_event(CMD_REPLY, 8'($urandom_range(0, 255)), kind);
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        send_event(cmd, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    endtask

    // ---------------------------------------------------------------- result checking

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.action       = m_axis_tuser;
            got.packet_kind  = m_axis_tdata[1:0];
            got.sequence_res = m_axis_tdata[33:2];
            got.payload_ref  = m_axis_tdata[41:34];
            got.status       = m_axis_tdata[45:42];
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("action", 32'(want.action), 32'(got.action));
                check_field("packet_kind", 32'(want.packet_kind), 32'(got.packet_kind));
                check_field("sequence_res", want.sequence_res, got.sequence_res);
                check_field("payload_ref", 32'(want.payload_ref), 32'(got.payload_ref));
                check_field("status", 32'(want.status), 32'(got.status));
            end
        end
    end

    // receiver back-pressure in bursts of random length
    always @(posedge clk)
    begin
        if (!rx_idle_en)
            m_axis_tready <= 1'b1;
        else if (rx_stall_left != 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            rx_stall_left <= $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- tests

    // defaults straight out of reset: 300-tick timeout, three retries
    task automatic test_reset_defaults();
        send_cmd(CMD_START);
        send_ticks(300);                  // hello timeout on the 300th tick
        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        send_cmd(CMD_START);
        send_reply(REPLY_ACK);
        send_cmd(CMD_LINE);
        send_ticks(3);                    // two resends, then the line is dropped
        send_cmd(CMD_EOF);
        send_reply(REPLY_ACK);
    endtask

    task automatic test_ignored_events();
        send_cmd(CMD_LINE);
        send_cmd(CMD_EOF);
        send_reply(REPLY_ACK);
        send_cmd(CMD_TICK);
        send_cmd(3'd5);
        send_cmd(3'd6);
        send_cmd(3'd7);
    endtask

    task automatic test_full_session();
        send_cmd(CMD_START);
        send_cmd(CMD_START);              // already busy
        send_reply(REPLY_ACK);
        send_cmd(CMD_TICK);               // open, not waiting
        send_reply(REPLY_NACK);           // open, not waiting
        send_event(CMD_LINE, 8'hFF, 2'd3);
        send_cmd(CMD_LINE);               // still waiting on the data packet
        send_reply(REPLY_NACK);
        send_reply(REPLY_OTHER);
        send_reply(2'd3);                 // undefined reply kind
        send_reply(REPLY_ACK);
        send_event(CMD_LINE, 8'h00, REPLY_ACK);
        send_reply(REPLY_ACK);
        send_cmd(CMD_EOF);
        send_reply(REPLY_ACK);
    endtask

    task automatic test_rejections();
        send_cmd(CMD_START);
        send_reply(REPLY_NACK);
        send_cmd(CMD_START);
        send_reply(REPLY_ACK);
        send_cmd(CMD_EOF);
        send_reply(REPLY_OTHER);
    endtask

    task automatic test_timeouts();
        write_reg(REG_RETRY_LIMIT, 16'h0002);
        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        send_cmd(CMD_START);
        send_ticks(1);
        send_cmd(CMD_START);
        send_reply(REPLY_ACK);
        send_cmd(CMD_LINE);
        send_ticks(2);
        send_cmd(CMD_EOF);
        send_ticks(1);
    endtask

    // zero in either register behaves as one
    task automatic test_zero_registers();
        write_reg(REG_RETRY_LIMIT, 16'hFFF0);
        write_reg(REG_TIMEOUT_TICKS, 16'd0);
        send_cmd(CMD_START);
        send_reply(REPLY_ACK);
        send_cmd(CMD_LINE);
        send_ticks(1);
        send_cmd(CMD_LINE);
        send_reply(REPLY_ACK);
        send_cmd(CMD_EOF);
        send_reply(REPLY_ACK);
    endtask

    task automatic test_retry_wrap();
        write_reg(REG_RETRY_LIMIT, 16'h000F);
        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        send_cmd(CMD_START);
        send_reply(REPLY_ACK);
        send_cmd(CMD_LINE);
        send_ticks(15);
        send_cmd(CMD_EOF);
        send_reply(REPLY_ACK);
    endtask

    // largest timeout: ticks accumulate without a result until a reply arrives
    task automatic test_longest_timeout();
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        send_cmd(CMD_START);
        send_ticks(40);
        send_reply(REPLY_ACK);
        send_cmd(CMD_EOF);
        send_ticks(40);
        send_reply(REPLY_ACK);
    endtask

    // Mostly events that fit the predicted phase, with a share of arbitrary noise.
    task automatic random_phase(input int unsigned acted_target);
        int unsigned acted_cnt;
        int unsigned pick;
        logic [2:0]  cmd;
        logic [1:0]  kind;
        acted_cnt = 0;
        while (acted_cnt < acted_target)
        begin
            pick = $urandom_range(0, 99);
            cmd  = CMD_TICK;
            kind = REPLY_ACK;
            if (pick < 8)
            begin
                cmd  = 3'($urandom_range(0, 7));
                kind = 2'($urandom_range(0, 3));
            end
            else
                case (sess_phase)
                    PH_IDLE: cmd = CMD_START;
                    PH_OPEN: cmd = (pick < 85) ? CMD_LINE : CMD_EOF;
                    PH_HELLO, PH_CLOSE:
                        if (pick < 70)
                            cmd = CMD_REPLY;
                        else if (pick < 85)
                        begin
                            cmd  = CMD_REPLY;
                            kind = 2'($urandom_range(1, 3));
                        end
                    default:
                        if (pick < 40)
                            cmd = CMD_REPLY;
                        else if (pick < 55)
                        begin
                            cmd  = CMD_REPLY;
                            kind = 2'($urandom_range(1, 3));
                        end
                endcase
            send_event(cmd, 8'($urandom_range(0, 255)), kind);
            if (last_acted)
                acted_cnt++;
        end
    endtask

    task automatic test_random_traffic();
        write_reg(REG_RETRY_LIMIT, {12'($urandom_range(0, 4095)), 4'd1});
        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        random_phase(85);
        write_reg(REG_RETRY_LIMIT, {12'($urandom_range(0, 4095)), 4'd15});
        write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(1, 4)));
        random_phase(85);
        write_reg(REG_RETRY_LIMIT, 16'($urandom_range(0, 65535)));
        write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(2, 6)));
        random_phase(85);
        write_reg(REG_RETRY_LIMIT, 16'd3);
        write_reg(REG_TIMEOUT_TICKS, 16'd3);
        // closing stretch at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_phase(85);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_ignored_events();
        test_full_session();
        test_rejections();
        test_timeouts();
        test_zero_registers();
        test_retry_wrap();
        test_longest_timeout();
        test_random_traffic();
        wait_quiet();
        repeat (10) @(posedge clk);
        $display("Covered %0d events (%0d acted on), %0d results checked, %0d register writes,",
                 events_sent, events_acted, results_checked, cfg_writes);
        $display("including hello, data and close timeouts, rejects, retries and dropped events.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
